// ===== rtl/tq_pkg.sv =====
// shared types, codes and default sizes of the team queue
package tq_pkg;

	// default sizes
	localparam int ELEMENTS_DEF = 1024;
	localparam int TEAMS_DEF    = 256;
	localparam int SLOTS_DEF    = 1024;

	// field widths fixed by the item format
	localparam int ELEM_FW = 10;
	localparam int TEAM_FW = 8;

	// item kinds
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_PUSH = 2'd1;
	localparam logic [1:0] KIND_POP  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [ELEM_FW-1:0] element;
		logic [TEAM_FW-1:0] team;
	} item_t;

	typedef struct packed {
		logic [ELEM_FW-1:0] popped;
		logic [1:0]         status;
	} result_t;

	// controller to datapath step commands
	typedef struct packed {
		logic accept;
		logic push_a;
		logic push_b;
		logic pop_a;
		logic pop_b;
		logic pop_c;
		logic finish;
	} tq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic full;
		logic empty;
		logic new_team;
	} tq_stat_t;

endpackage

// ===== rtl/tq_ctrl.sv =====
// sequencing state machine of the team queue
module tq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      kind,
	input  tq_pkg::tq_stat_t stat,
	output logic            busy,
	output tq_pkg::tq_cmd_t cmd
);
	import tq_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_PUSH_A = 6'b000010,
		S_PUSH_B = 6'b000100,
		S_POP_A  = 6'b001000,
		S_POP_B  = 6'b010000,
		S_POP_C  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   long_push, long_pop;

	assign long_push = (kind == KIND_PUSH) && !stat.full;
	assign long_pop  = (kind == KIND_POP) && !stat.empty;
	assign busy      = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.accept = start;
				if (start) begin
					if (long_push) begin
						state_d = S_PUSH_A;
					end else if (long_pop) begin
						state_d = S_POP_A;
					end else begin
						cmd.finish = 1'b1;
					end
				end
			end
			S_PUSH_A: begin
				cmd.push_a = 1'b1;
				if (stat.new_team) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					state_d = S_PUSH_B;
				end
			end
			S_PUSH_B: begin
				cmd.push_b = 1'b1;
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			S_POP_A: begin
				cmd.pop_a = 1'b1;
				state_d   = S_POP_B;
			end
			S_POP_B: begin
				cmd.pop_b = 1'b1;
				state_d   = S_POP_C;
			end
			S_POP_C: begin
				cmd.pop_c  = 1'b1;
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/tq_datapath.sv =====
// memories, pointers and result register of the team queue
module tq_datapath #(
	parameter int ELEMENTS = tq_pkg::ELEMENTS_DEF,
	parameter int TEAMS    = tq_pkg::TEAMS_DEF,
	parameter int SLOTS    = tq_pkg::SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tq_pkg::item_t    item,
	input  tq_pkg::tq_cmd_t  cmd,
	output tq_pkg::tq_stat_t stat,
	output logic             done,
	output tq_pkg::result_t  result
);
	import tq_pkg::*;

	localparam int ELEM_AW = $clog2(ELEMENTS);
	localparam int TEAM_W  = $clog2(TEAMS);
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int TAB_N   = 2 ** TEAM_FW;

	// memories
	logic [TEAM_W-1:0]  mem_member [ELEMENTS];
	logic [ELEM_FW-1:0] mem_sval   [SLOTS];
	logic [SLOT_W-1:0]  mem_slink  [SLOTS];
	logic [SLOT_W-1:0]  mem_thead  [TEAMS];
	logic [SLOT_W-1:0]  mem_ttail  [TEAMS];
	logic [TEAM_W-1:0]  mem_order  [TEAMS];

	// registered read data
	logic [TEAM_W-1:0]  member_rd_q;
	logic [ELEM_FW-1:0] sval_rd_q;
	logic [SLOT_W-1:0]  slink_rd_q;
	logic [SLOT_W-1:0]  thead_rd_q;
	logic [SLOT_W-1:0]  ttail_rd_q;
	logic [TEAM_W-1:0]  order_rd_q;

	// control state
	logic [SLOT_W-1:0]  free_head_q;
	logic [CNT_W-1:0]   free_count_q;
	logic [CNT_W-1:0]   fresh_q;
	logic [TEAM_W-1:0]  order_front_q;
	logic [TEAM_W-1:0]  order_back_q;
	logic [TEAMS-1:0]   active_q;
	logic               done_q;
	result_t            result_q;

	// item payload
	logic [ELEM_FW-1:0] element_q;
	logic [SLOT_W-1:0]  alloc_q;
	logic [TEAM_W-1:0]  team_q;

	logic [TEAM_W-1:0]  team_tab [TAB_N];
	logic [ELEM_AW-1:0] in_addr;
	logic               in_range_in, in_range_q;
	logic [TEAM_W-1:0]  t_push;
	logic [TEAM_W-1:0]  t_raddr;
	logic [SLOT_W-1:0]  slink_raddr;
	logic               is_fresh;
	logic [SLOT_W-1:0]  head_inc;
	logic [SLOT_W-1:0]  next_free;
	logic               last_in_team;
	logic [TEAM_W-1:0]  back_inc, front_inc;
	logic [1:0]         quick_status;

	// team number modulo the team count, as a constant table
	for (genvar g = 0; g < TAB_N; g++) begin : g_tab
		assign team_tab[g] = TEAM_W'(g % TEAMS);
	end

	assign in_addr     = ELEM_AW'(item.element);
	assign in_range_in = 32'(item.element) < 32'(ELEMENTS);
	assign in_range_q  = 32'(element_q) < 32'(ELEMENTS);
	assign t_push      = in_range_q ? member_rd_q : '0;
	assign t_raddr     = cmd.pop_a ? order_rd_q : t_push;
	assign slink_raddr = cmd.pop_b ? thead_rd_q : free_head_q;

	// slots at or above the fresh mark were never linked and chain to the next index
	assign is_fresh  = {1'b0, free_head_q} >= fresh_q;
	assign head_inc  = (free_head_q == SLOT_W'(SLOTS - 1)) ? '0 : free_head_q + 1'b1;
	assign next_free = is_fresh ? head_inc : slink_rd_q;

	assign last_in_team = (thead_rd_q == ttail_rd_q);
	assign back_inc  = (order_back_q == TEAM_W'(TEAMS - 1)) ? '0 : order_back_q + 1'b1;
	assign front_inc = (order_front_q == TEAM_W'(TEAMS - 1)) ? '0 : order_front_q + 1'b1;

	assign stat.full     = (free_count_q == '0);
	assign stat.empty    = (free_count_q == CNT_W'(SLOTS));
	assign stat.new_team = !active_q[t_push];

	always_comb begin
		quick_status = ST_OK;
		if (item.kind == KIND_PUSH && stat.full) begin
			quick_status = ST_FULL;
		end else if (item.kind == KIND_POP && stat.empty) begin
			quick_status = ST_EMPTY;
		end
	end

	// membership table
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			member_rd_q <= mem_member[in_addr];
			if (item.kind == KIND_LOAD && in_range_in) begin
				mem_member[in_addr] <= team_tab[item.team];
			end
		end
	end

	// slot values
	always_ff @(posedge clk) begin
		if (cmd.pop_b) begin
			sval_rd_q <= mem_sval[thead_rd_q];
		end
		if (cmd.push_a) begin
			mem_sval[free_head_q] <= element_q;
		end
	end

	// slot links
	always_ff @(posedge clk) begin
		if (cmd.accept || cmd.pop_b) begin
			slink_rd_q <= mem_slink[slink_raddr];
		end
		if (cmd.push_b) begin
			mem_slink[ttail_rd_q] <= alloc_q;
		end else if (cmd.pop_c) begin
			mem_slink[thead_rd_q] <= free_head_q;
		end
	end

	// team heads and tails
	always_ff @(posedge clk) begin
		if (cmd.push_a || cmd.pop_a) begin
			thead_rd_q <= mem_thead[t_raddr];
			ttail_rd_q <= mem_ttail[t_raddr];
		end
		if (cmd.push_a && !active_q[t_push]) begin
			mem_thead[t_push] <= free_head_q;
		end else if (cmd.pop_c && !last_in_team) begin
			mem_thead[team_q] <= slink_rd_q;
		end
		if (cmd.push_a) begin
			mem_ttail[t_push] <= free_head_q;
		end
	end

	// team order ring
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			order_rd_q <= mem_order[order_front_q];
		end
		if (cmd.push_a && !active_q[t_push]) begin
			mem_order[order_back_q] <= t_push;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			element_q <= item.element;
		end
		if (cmd.push_a) begin
			alloc_q <= free_head_q;
		end
		if (cmd.pop_a) begin
			team_q <= order_rd_q;
		end
		if (cmd.finish) begin
			result_q.popped <= cmd.pop_c ? sval_rd_q : '0;
			result_q.status <= cmd.accept ? quick_status : ST_OK;
		end
	end

	// pointers, counts and team flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q   <= '0;
			free_count_q  <= CNT_W'(SLOTS);
			fresh_q       <= '0;
			order_front_q <= '0;
			order_back_q  <= '0;
			active_q      <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.push_a) begin
				free_head_q  <= next_free;
				free_count_q <= free_count_q - 1'b1;
				if (is_fresh) begin
					fresh_q <= {1'b0, free_head_q} + 1'b1;
				end
				if (!active_q[t_push]) begin
					active_q[t_push] <= 1'b1;
					order_back_q     <= back_inc;
				end
			end
			if (cmd.pop_c) begin
				free_head_q  <= thead_rd_q;
				free_count_q <= free_count_q + 1'b1;
				if (last_in_team) begin
					active_q[team_q] <= 1'b0;
					order_front_q    <= front_inc;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/team_queue.sv =====
// team queue top level: controller and datapath
//
//  channel   handshake          payload             notes
//  item      start / busy       item   (item_t)     transfer when start high and busy low
//  result    done               result (result_t)   one cycle wide, one per item
//
// states after transfer: none for load, unused kind, push while full, pop while empty;
// push_a to queue a new team, push_a and push_b to join a queued team, pop_a to pop_c for a pop
// each step waits on one registered memory read, order -> team head -> slot sets the pop
// the next item can transfer in the cycle done is high
// reset clears the counts, fresh slot mark, order pointers and team flags; no clearing pass
// done cannot be held off by the receiver
module team_queue #(
	parameter int ELEMENTS = tq_pkg::ELEMENTS_DEF,
	parameter int TEAMS    = tq_pkg::TEAMS_DEF,
	parameter int SLOTS    = tq_pkg::SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  tq_pkg::item_t   item,
	output logic            done,
	output tq_pkg::result_t result
);
	import tq_pkg::*;

	// step commands and datapath status
	tq_cmd_t  cmd;
	tq_stat_t stat;

	// sequencer: one state per dependent memory step
	tq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// memories, free list, order ring and result register
	tq_datapath #(
		.ELEMENTS (ELEMENTS),
		.TEAMS    (TEAMS),
		.SLOTS    (SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

`ifndef SYNTHESIS
	// the result strobe only comes on the way back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a transfer either finishes at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("transfer lost");

	// the free count cannot read empty and full together
	a_count_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("free count both full and empty");
`endif

endmodule

// ===== test/tq_check.sv =====
// team queue checker: predicts each result from accepted items and compares
module tq_check #(
	parameter int ELEMENTS = tq_pkg::ELEMENTS_DEF,
	parameter int TEAMS    = tq_pkg::TEAMS_DEF,
	parameter int SLOTS    = tq_pkg::SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  tq_pkg::item_t   item,
	input  logic            done,
	input  tq_pkg::result_t result,
	output int              errors,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tq_pkg::*;

	localparam int SW = $clog2(SLOTS);

	// predicted queue state
	logic [TEAM_FW-1:0] team_of [ELEMENTS];
	logic [ELEM_FW-1:0] slot_elem [SLOTS];
	logic [SW-1:0]      next_slot [SLOTS];
	logic [SW-1:0]      free_top;
	int unsigned        free_slots;
	logic [SW-1:0]      head_of [TEAMS];
	logic [SW-1:0]      tail_of [TEAMS];
	bit                 queued [TEAMS];
	logic [TEAM_FW-1:0] team_order [TEAMS];
	int unsigned        front_pos;
	int unsigned        back_pos;

	result_t awaited_results [$];

	function automatic void clear_queue();
		for (int i = 0; i < ELEMENTS; i++) team_of[i] = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_elem[i] = '0;
			next_slot[i] = SW'((i + 1) % SLOTS);
		end
		for (int i = 0; i < TEAMS; i++) begin
			head_of[i] = '0;
			tail_of[i] = '0;
			queued[i] = 1'b0;
			team_order[i] = '0;
		end
		free_top = '0;
		free_slots = SLOTS;
		front_pos = 0;
		back_pos = 0;
	endfunction

	// apply one item to the predicted state and return its result
	function automatic result_t queue_step(item_t it);
		result_t r;
		int unsigned t;
		logic [SW-1:0] s;
		r = '{popped: '0, status: ST_OK};
		case (it.kind)
			KIND_LOAD: begin
				if (it.element < ELEMENTS) team_of[it.element] = TEAM_FW'(it.team % TEAMS);
			end
			KIND_PUSH: begin
				if (free_slots == 0) begin
					r.status = ST_FULL;
				end else begin
					t = (it.element < ELEMENTS) ? team_of[it.element] % TEAMS : 0;
					s = free_top;
					free_top = next_slot[s];
					free_slots--;
					slot_elem[s] = it.element;
					if (queued[t]) begin
						next_slot[tail_of[t]] = s;
						tail_of[t] = s;
					end else begin
						queued[t] = 1'b1;
						head_of[t] = s;
						tail_of[t] = s;
						team_order[back_pos] = TEAM_FW'(t);
						back_pos = (back_pos + 1) % TEAMS;
					end
				end
			end
			KIND_POP: begin
				if (free_slots >= SLOTS) begin
					r.status = ST_EMPTY;
				end else begin
					t = team_order[front_pos] % TEAMS;
					s = head_of[t];
					r.popped = slot_elem[s];
					if (s == tail_of[t]) begin
						queued[t] = 1'b0;
						front_pos = (front_pos + 1) % TEAMS;
					end else begin
						head_of[t] = next_slot[s];
					end
					next_slot[s] = free_top;
					free_top = s;
					free_slots++;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_queue();
			awaited_results.delete();
			errors = 0;
		end else begin
			// a result strobe always belongs to an earlier transfer
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result with nothing awaited: popped %0d status %0d",
						result.popped, result.status);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (result.popped !== want.popped) begin
						$error("popped: expected %0d, got %0d", want.popped, result.popped);
						errors++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						errors++;
					end
				end
			end
			if (start && !busy) awaited_results.push_back(queue_step(item));
		end
		pending = awaited_results.size();
	end

endmodule

// ===== test/tb.sv =====
// team queue testbench top: stimulus, watchdog and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tq_pkg::*;

	// kind with no meaning, the block must answer ok and change nothing
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int STALL_LIMIT = 400;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;
	int      errors;
	int      pending;

	// stimulus bookkeeping: which elements have a team, how many slots are taken
	bit                 is_member [ELEMENTS_DEF];
	logic [ELEM_FW-1:0] member_ids [$];
	int                 occupancy;
	bit                 idle_on;
	int                 quiet_cycles;

	team_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	tq_check check (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: any transfer or result strobe counts as progress
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL team_queue");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one item and hold it until the transfer happens
	// busy is looked at on the falling edge, where it is settled
	task automatic send_item(input logic [1:0] k, input logic [ELEM_FW-1:0] e,
			input logic [TEAM_FW-1:0] t);
		bit taken;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{kind: k, element: e, team: t};
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic load_member(input logic [ELEM_FW-1:0] e, input logic [TEAM_FW-1:0] t);
		send_item(KIND_LOAD, e, t);
		if (!is_member[e]) begin
			is_member[e] = 1'b1;
			member_ids.push_back(e);
		end
	endtask

	// only elements with a loaded team are ever pushed
	task automatic push_elem(input logic [ELEM_FW-1:0] e);
		send_item(KIND_PUSH, e, TEAM_FW'($urandom));
		if (occupancy < SLOTS_DEF) occupancy++;
	endtask

	task automatic pop_front();
		send_item(KIND_POP, ELEM_FW'($urandom), TEAM_FW'($urandom));
		if (occupancy > 0) occupancy--;
	endtask

	// mostly a dozen teams so members pile up behind each other, sometimes any team
	function automatic logic [TEAM_FW-1:0] pick_team();
		if ($urandom_range(0, 9) < 7) return TEAM_FW'($urandom_range(0, 11));
		return TEAM_FW'($urandom);
	endfunction

	function automatic logic [ELEM_FW-1:0] pick_member();
		return member_ids[$urandom_range(0, member_ids.size() - 1)];
	endfunction

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20 || member_ids.size() == 0)
			load_member(ELEM_FW'($urandom), pick_team());
		else if (pick < 62)
			push_elem(pick_member());
		else if (pick < 95)
			pop_front();
		else
			send_item(KIND_SPARE, ELEM_FW'($urandom), TEAM_FW'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		occupancy = 0;
		idle_on = 1'b1;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, spare kind, field extremes, reload of a team
		pop_front();
		send_item(KIND_SPARE, '1, '1);
		load_member('0, '0);
		load_member('1, '1);
		load_member(10'd5, '1);
		load_member(10'd7, 8'd3);
		load_member(10'd5, 8'd128);
		push_elem('1);        // team 255 joins the order
		push_elem('0);        // team 0 joins behind it
		push_elem(10'd7);
		push_elem(10'd5);
		push_elem('1);        // lands behind the first member of team 255
		push_elem('0);
		repeat (6) pop_front();
		pop_front();          // empty again

		// random mix with idle bursts
		repeat (360) random_item();

		// spread members over many teams
		repeat (32) load_member(ELEM_FW'($urandom), TEAM_FW'($urandom));
		// drain completely and pop past empty
		while (occupancy > 0) pop_front();
		repeat (2) pop_front();

		// closing stretch with no idling
		idle_on = 1'b0;
		repeat (100) random_item();
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS team_queue");
		else
			$display("FAIL team_queue");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tq_pkg.sv
rtl/tq_ctrl.sv
rtl/tq_datapath.sv
rtl/team_queue.sv
test/tq_check.sv
test/tb.sv
